// ===== src/tof_pkg.sv =====
package tof_pkg;

  // Telnet command octets.
  localparam logic [7:0] OCT_IAC  = 8'd255;
  localparam logic [7:0] OCT_DONT = 8'd254;
  localparam logic [7:0] OCT_DO   = 8'd253;
  localparam logic [7:0] OCT_WONT = 8'd252;
  localparam logic [7:0] OCT_WILL = 8'd251;
  localparam logic [7:0] OCT_SB   = 8'd250;
  localparam logic [7:0] OCT_SE   = 8'd240;

  // Option codes.
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_NAWS   = 8'd31;

  // Number of subnegotiation octets that are kept.
  localparam int unsigned HEAD_LEN = 5;
  localparam int unsigned HEAD_IDX_W = 3;

  // Bit positions in the pending verb flags.
  localparam int unsigned VB_DO   = 0;
  localparam int unsigned VB_DONT = 1;
  localparam int unsigned VB_WILL = 2;
  localparam int unsigned VB_WONT = 3;

  // Window size after reset.
  localparam logic [15:0] COLS_DEFAULT = 16'd80;
  localparam logic [15:0] ROWS_DEFAULT = 16'd24;

  // Outcome of one received octet.
  typedef enum logic [1:0] {
    STATUS_DATA = 2'd0,
    STATUS_CMD  = 2'd1,
    STATUS_DROP = 2'd2
  } status_t;

  // One result as it leaves the filter.
  typedef struct packed {
    status_t     status;
    logic [7:0]  data_byte;
    logic        size_changed;
    logic [15:0] window_cols;
    logic [15:0] window_rows;
    logic        binary_mode;
  } result_t;

endpackage

// ===== src/tof_parser.sv =====
module tof_parser import tof_pkg::*; #(
  parameter int unsigned SUBNEG_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  localparam int unsigned CNT_W = $clog2(SUBNEG_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(SUBNEG_CAPACITY);
  localparam logic [CNT_W-1:0] HEAD_CNT = CNT_W'(HEAD_LEN);

  // Parser state.
  logic             after_iac;
  logic             in_subneg;
  logic [3:0]       pending_verb;
  logic [CNT_W-1:0] subneg_count;
  logic [7:0]       subneg_head [HEAD_LEN];
  logic [15:0]      cols_reg;
  logic [15:0]      rows_reg;
  logic             binary_flag;

  logic             after_iac_next;
  logic             in_subneg_next;
  logic [3:0]       pending_verb_next;
  logic [CNT_W-1:0] subneg_count_next;
  logic [15:0]      cols_reg_next;
  logic [15:0]      rows_reg_next;
  logic             binary_flag_next;
  logic             head_we;
  logic             changed;
  status_t          status;
  logic [7:0]       data_out;

  logic       is_iac;
  logic       open_cmd;
  logic       cmd;
  logic [15:0] naws_w;
  logic [15:0] naws_h;

  assign is_iac   = (rx_byte == OCT_IAC);
  assign open_cmd = is_iac && !after_iac;
  assign cmd      = after_iac && !is_iac;
  assign naws_w   = {subneg_head[1], subneg_head[2]};
  assign naws_h   = {subneg_head[3], subneg_head[4]};

  // Decode of one octet against the current state.
  always_comb begin
    after_iac_next    = open_cmd;
    in_subneg_next    = in_subneg;
    pending_verb_next = pending_verb;
    subneg_count_next = subneg_count;
    cols_reg_next     = cols_reg;
    rows_reg_next     = rows_reg;
    binary_flag_next  = binary_flag;
    head_we           = 1'b0;
    changed           = 1'b0;
    status            = STATUS_CMD;
    data_out          = 8'd0;

    if (cmd) begin
      unique case (rx_byte)
        OCT_SB: begin
          subneg_count_next = '0;
          in_subneg_next    = 1'b1;
        end
        OCT_SE: begin
          if (in_subneg) begin
            if ((subneg_count >= HEAD_CNT) && (subneg_head[0] == OPT_NAWS)) begin
              if (naws_w != 16'd0) begin
                cols_reg_next = naws_w;
                changed       = 1'b1;
              end
              if (naws_h != 16'd0) begin
                rows_reg_next = naws_h;
                changed       = 1'b1;
              end
            end
            subneg_count_next = '0;
            in_subneg_next    = 1'b0;
          end
        end
        OCT_DONT:   pending_verb_next[VB_DONT] = 1'b1;
        OCT_DO:     pending_verb_next[VB_DO]   = 1'b1;
        OCT_WONT:   pending_verb_next[VB_WONT] = 1'b1;
        OCT_WILL:   pending_verb_next[VB_WILL] = 1'b1;
        OPT_BINARY: binary_flag_next = pending_verb[VB_DO];
        default: ;
      endcase
    end else if (!open_cmd) begin
      // A plain octet, or a literal 255 from a doubled IAC.
      if (in_subneg) begin
        if (subneg_count == CAP) begin
          status = STATUS_DROP;
        end else begin
          head_we           = (subneg_count < HEAD_CNT);
          subneg_count_next = subneg_count + CNT_W'(1);
        end
      end else if (pending_verb[VB_DONT]) begin
        pending_verb_next[VB_DONT] = 1'b0;
      end else if (pending_verb[VB_DO]) begin
        pending_verb_next[VB_DO] = 1'b0;
      end else if (pending_verb[VB_WONT]) begin
        pending_verb_next[VB_WONT] = 1'b0;
      end else if (pending_verb[VB_WILL]) begin
        pending_verb_next[VB_WILL] = 1'b0;
      end else begin
        status   = STATUS_DATA;
        data_out = rx_byte;
      end
    end
  end

  // Result carries the state as it stands after this octet.
  always_comb begin
    res.status       = status;
    res.data_byte    = data_out;
    res.size_changed = changed;
    res.window_cols  = cols_reg_next;
    res.window_rows  = rows_reg_next;
    res.binary_mode  = binary_flag_next;
  end

  // State registers advance once per octet.
  always_ff @(posedge clk) begin
    if (rst) begin
      after_iac    <= 1'b0;
      in_subneg    <= 1'b0;
      pending_verb <= '0;
      subneg_count <= '0;
      cols_reg     <= COLS_DEFAULT;
      rows_reg     <= ROWS_DEFAULT;
      binary_flag  <= 1'b0;
    end else if (fire) begin
      after_iac    <= after_iac_next;
      in_subneg    <= in_subneg_next;
      pending_verb <= pending_verb_next;
      subneg_count <= subneg_count_next;
      cols_reg     <= cols_reg_next;
      rows_reg     <= rows_reg_next;
      binary_flag  <= binary_flag_next;
    end
  end

  // The first octets of a subnegotiation are kept for the NAWS check.
  always_ff @(posedge clk) begin
    if (fire && head_we) begin
      subneg_head[subneg_count[HEAD_IDX_W-1:0]] <= rx_byte;
    end
  end

  // The buffer count stays within capacity and is empty outside a subnegotiation.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (subneg_count <= CAP) && (in_subneg || (subneg_count == '0)))
    else $error("subnegotiation count out of range");

  // An overflow leaves the subnegotiation state untouched.
  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    fire && (res.status == STATUS_DROP) |=> in_subneg && (subneg_count == CAP))
    else $error("overflow changed subnegotiation state");

  // A window update only comes from closing a subnegotiation.
  a_size_close: assert property (@(posedge clk) disable iff (rst)
    fire && res.size_changed |-> in_subneg && cmd && (rx_byte == OCT_SE))
    else $error("size change outside SE");

  a_size_after: assert property (@(posedge clk) disable iff (rst)
    fire && res.size_changed |=> !in_subneg && (subneg_count == '0))
    else $error("subnegotiation not closed after size change");

endmodule

// ===== src/tof_out_reg.sv =====
module tof_out_reg import tof_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    in_v,
  input  result_t res_in,
  output logic    out_valid,
  output result_t res_out
);

  // Result register: refills whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== src/telnet_option_filter.sv =====
// Channel   Handshake             Fields
// input     in_valid / in_stall   rx_byte
// output    out_valid / out_stall status, data_byte, size_changed,
//                                 window_cols, window_rows, binary_mode
//
// One request per clock is accepted unless in_stall holds it; each passes the
// input register, the octet decode and the result register. The decode reads
// and updates the parser state in the same cycle.
// Synchronous reset sets the window to 80 by 24 and clears the parser state
// but for the subnegotiation octets that are kept.
// A stall on the output holds the result register; the input register still
// takes one request while the result waits, then stalls the input.
module telnet_option_filter import tof_pkg::*; #(
  parameter int unsigned SUBNEG_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  data_byte,
  output logic        size_changed,
  output logic [15:0] window_cols,
  output logic [15:0] window_rows,
  output logic        binary_mode
);

  logic       in_v;
  logic [7:0] in_byte;
  logic       advance;
  result_t    res_comb;
  result_t    res_reg;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_v && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!in_stall) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  tof_parser #(
    .SUBNEG_CAPACITY(SUBNEG_CAPACITY)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (in_v && advance),
    .rx_byte (in_byte),
    .res     (res_comb)
  );

  tof_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_v      (in_v),
    .res_in    (res_comb),
    .out_valid (out_valid),
    .res_out   (res_reg)
  );

  assign status       = res_reg.status;
  assign data_byte    = res_reg.data_byte;
  assign size_changed = res_reg.size_changed;
  assign window_cols  = res_reg.window_cols;
  assign window_rows  = res_reg.window_rows;
  assign binary_mode  = res_reg.binary_mode;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
module tb import tof_pkg::*;;

  localparam int unsigned SUBNEG_CAP = 64;
  localparam int unsigned RANDOM_OCTETS = 1150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam logic [7:0] OCT_NOP = 8'd241;

  typedef struct packed {
    logic [7:0] octet;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic [7:0]  data_byte;
  logic        size_changed;
  logic [15:0] window_cols;
  logic [15:0] window_rows;
  logic        binary_mode;

  // Parser state as the filter should hold it.
  logic        st_cmd_open = 1'b0;
  logic        st_in_sb = 1'b0;
  logic [3:0]  st_verbs = 4'b0000;
  int unsigned st_sb_len = 0;
  logic [7:0]  st_sb_head [HEAD_LEN];
  logic [15:0] st_cols = COLS_DEFAULT;
  logic [15:0] st_rows = ROWS_DEFAULT;
  logic        st_binary = 1'b0;

  result_t     octet_outcomes [$];
  stim_row_t   directed_rows [$];
  int unsigned octets_fed = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned hold_req = 0;
  bit          gaps_on = 1'b0;

  telnet_option_filter #(.SUBNEG_CAPACITY(SUBNEG_CAP)) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .data_byte    (data_byte),
    .size_changed (size_changed),
    .window_cols  (window_cols),
    .window_rows  (window_rows),
    .binary_mode  (binary_mode)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Classify one octet and advance the predicted parser state.
  function automatic result_t filter_octet(input logic [7:0] b);
    result_t     r;
    logic        done;
    logic [15:0] w;
    logic [15:0] h;
    r = '0;
    r.status = STATUS_CMD;
    done = 1'b0;
    if (b == OCT_IAC) begin
      if (!st_cmd_open) begin
        st_cmd_open = 1'b1;
        done = 1'b1;
      end else begin
        st_cmd_open = 1'b0;
      end
    end
    // A command octet right after IAC.
    if (!done && st_cmd_open) begin
      unique case (b)
        OCT_SB: begin
          st_sb_len = 0;
          st_in_sb = 1'b1;
        end
        OCT_SE: begin
          if (st_in_sb) begin
            if (st_sb_len >= HEAD_LEN && st_sb_head[0] == OPT_NAWS) begin
              w = {st_sb_head[1], st_sb_head[2]};
              h = {st_sb_head[3], st_sb_head[4]};
              if (w != 16'd0) begin
                st_cols = w;
                r.size_changed = 1'b1;
              end
              if (h != 16'd0) begin
                st_rows = h;
                r.size_changed = 1'b1;
              end
            end
            st_sb_len = 0;
            st_in_sb = 1'b0;
          end
        end
        OCT_DONT:   st_verbs[VB_DONT] = 1'b1;
        OCT_DO:     st_verbs[VB_DO] = 1'b1;
        OCT_WONT:   st_verbs[VB_WONT] = 1'b1;
        OCT_WILL:   st_verbs[VB_WILL] = 1'b1;
        OPT_BINARY: st_binary = st_verbs[VB_DO];
        default: ;
      endcase
      st_cmd_open = 1'b0;
      done = 1'b1;
    end
    // Plain octet: buffered, eaten by an armed verb, or passed to the user.
    if (!done) begin
      if (st_in_sb) begin
        if (st_sb_len >= SUBNEG_CAP) begin
          r.status = STATUS_DROP;
        end else begin
          if (st_sb_len < HEAD_LEN) st_sb_head[st_sb_len] = b;
          st_sb_len++;
        end
      end else if (st_verbs[VB_DONT]) begin
        st_verbs[VB_DONT] = 1'b0;
      end else if (st_verbs[VB_DO]) begin
        st_verbs[VB_DO] = 1'b0;
      end else if (st_verbs[VB_WONT]) begin
        st_verbs[VB_WONT] = 1'b0;
      end else if (st_verbs[VB_WILL]) begin
        st_verbs[VB_WILL] = 1'b0;
      end else begin
        r.status = STATUS_DATA;
        r.data_byte = b;
      end
    end
    r.window_cols = st_cols;
    r.window_rows = st_rows;
    r.binary_mode = st_binary;
    return r;
  endfunction

  function automatic result_t outcome(input status_t s, input logic [7:0] d,
                                      input logic [15:0] c, input logic [15:0] r,
                                      input logic bin);
    return {s, d, 1'b0, c, r, bin};
  endfunction

  function automatic void add_row(input logic [7:0] o, input logic typed = 1'b0,
                                  input result_t want = '0);
    directed_rows.insert(directed_rows.size(), {o, typed, want});
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_verb();
    case ($urandom_range(0, 3))
      0: return OCT_DO;
      1: return OCT_DONT;
      2: return OCT_WILL;
      default: return OCT_WONT;
    endcase
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Offer one request, wait until it is taken, then record its outcome.
  task automatic feed(input logic [7:0] b, input logic typed = 1'b0,
                      input result_t want = '0);
    int unsigned gap;
    result_t     predicted;
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = filter_octet(b);
    octet_outcomes.insert(octet_outcomes.size(), typed ? want : predicted);
    octets_fed++;
  endtask

  // A 255 inside a sequence has to be sent doubled.
  task automatic feed_escaped(input logic [7:0] b);
    feed(b);
    if (b == OCT_IAC) feed(b);
  endtask

  task automatic feed_subneg(input logic [7:0] opt, input int unsigned len);
    feed(OCT_IAC);
    feed(OCT_SB);
    feed_escaped(opt);
    repeat (len) feed_escaped(8'($urandom));
    feed(OCT_IAC);
    feed(OCT_SE);
  endtask

  // Stop offering and wait until every outcome has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (octet_outcomes.size() != 0) @(posedge clk);
  endtask

  // One random sequence, mostly well formed, some plain noise.
  task automatic feed_sequence();
    int unsigned kind;
    logic [15:0] w;
    logic [15:0] h;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      repeat ($urandom_range(1, 6)) feed_escaped(8'($urandom));
    end else if (kind < 40) begin
      feed(OCT_IAC);
      feed(pick_verb());
      if ($urandom_range(0, 2) == 0) begin
        feed(OCT_IAC);
        feed(pick_verb());
        feed_escaped(8'($urandom));
      end
      feed_escaped(8'($urandom));
    end else if (kind < 48) begin
      if ($urandom_range(0, 3) != 0) begin
        feed(OCT_IAC);
        feed($urandom_range(0, 1) ? OCT_DO : OCT_DONT);
      end
      feed(OCT_IAC);
      feed(OPT_BINARY);
      feed_escaped(8'($urandom));
    end else if (kind < 54) begin
      feed(OCT_IAC);
      feed($urandom_range(0, 1) ? 8'($urandom_range(OCT_SE, OCT_SB)) : 8'($urandom));
    end else if (kind < 72) begin
      w = pick_dim();
      h = pick_dim();
      feed(OCT_IAC);
      feed(OCT_SB);
      feed(OPT_NAWS);
      feed_escaped(w[15:8]);
      feed_escaped(w[7:0]);
      feed_escaped(h[15:8]);
      feed_escaped(h[7:0]);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) feed_escaped(8'($urandom));
      feed(OCT_IAC);
      feed(OCT_SE);
    end else if (kind < 80) begin
      feed_subneg(8'($urandom), $urandom_range(0, 8));
    end else if (kind < 85) begin
      // NAWS too short to carry a window size.
      feed(OCT_IAC);
      feed(OCT_SB);
      feed(OPT_NAWS);
      repeat ($urandom_range(0, 3)) feed_escaped(8'($urandom));
      feed(OCT_IAC);
      feed(OCT_SE);
    end else if (kind < 87) begin
      feed_subneg(8'($urandom), $urandom_range(58, 70));
    end else begin
      repeat ($urandom_range(1, 8))
        feed($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(OCT_SE, OCT_IAC)));
    end
  endtask

  // Take results, compare them with the oldest prediction, and stall at random.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (octet_outcomes.size() == 0) begin
        flag_mismatch("result arrived with no request pending");
      end else begin
        want = octet_outcomes.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
        if (data_byte !== want.data_byte)
          flag_mismatch($sformatf("data_byte %h, predicted %h", data_byte, want.data_byte));
        if (size_changed !== want.size_changed)
          flag_mismatch($sformatf("size_changed %b, predicted %b",
                                  size_changed, want.size_changed));
        if (window_cols !== want.window_cols)
          flag_mismatch($sformatf("window_cols %0d, predicted %0d",
                                  window_cols, want.window_cols));
        if (window_rows !== want.window_rows)
          flag_mismatch($sformatf("window_rows %0d, predicted %0d",
                                  window_rows, want.window_rows));
        if (binary_mode !== want.binary_mode)
          flag_mismatch($sformatf("binary_mode %b, predicted %b",
                                  binary_mode, want.binary_mode));
      end
    end
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end else if (stall_left == 0 && gaps_on) begin
      stall_left = idle_len();
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Give up when neither side has moved a request for too long.
  always @(posedge clk) begin
    if (rst || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned random_base;
    int unsigned target;
    // Plain data right after reset, then IAC alone and doubled.
    add_row(8'h00, 1'b1, outcome(STATUS_DATA, 8'h00, COLS_DEFAULT, ROWS_DEFAULT, 1'b0));
    add_row(OCT_IAC, 1'b1, outcome(STATUS_CMD, 8'h00, COLS_DEFAULT, ROWS_DEFAULT, 1'b0));
    add_row(OCT_IAC, 1'b1, outcome(STATUS_DATA, 8'hFF, COLS_DEFAULT, ROWS_DEFAULT, 1'b0));
    // DO armed, so BINARY turns binary mode on.
    add_row(OCT_IAC);
    add_row(OCT_DO);
    add_row(OCT_IAC);
    add_row(OPT_BINARY, 1'b1, outcome(STATUS_CMD, 8'h00, COLS_DEFAULT, ROWS_DEFAULT, 1'b1));
    // All four verbs armed; a doubled IAC and three octets clear them in order.
    add_row(OCT_IAC);
    add_row(OCT_DONT);
    add_row(OCT_IAC);
    add_row(OCT_WILL);
    add_row(OCT_IAC);
    add_row(OCT_WONT);
    add_row(OCT_IAC);
    add_row(OCT_IAC);
    add_row(8'h2A);
    add_row(8'h55);
    add_row(8'h80);
    add_row(8'h7F);
    // Other command, and SE with no subnegotiation open.
    add_row(OCT_IAC);
    add_row(OCT_NOP);
    add_row(OCT_IAC);
    add_row(OCT_SE);
    // NAWS with a zero width and a height of 256.
    add_row(OCT_IAC);
    add_row(OCT_SB);
    add_row(OPT_NAWS);
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h01);
    add_row(8'h00);
    add_row(OCT_IAC);
    add_row(OCT_SE);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      feed(row.octet, row.typed, row.want);
    end
    settle();

    // Overfill the subnegotiation buffer once for sure.
    feed_subneg(8'h18, SUBNEG_CAP + 2);
    random_base = octets_fed;
    for (int phase = 0; phase < 4; phase++) begin
      gaps_on = (phase != 1);
      // Back-to-back requests against a long output hold.
      if (phase == 1) hold_req = LONG_HOLD;
      target = random_base + (phase + 1) * RANDOM_OCTETS / 4;
      while (octets_fed < target) feed_sequence();
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tof_pkg.sv
src/tof_parser.sv
src/tof_out_reg.sv
src/telnet_option_filter.sv
sim/tb.sv
